[rtl/core/visibility_phase_rotate_accumulate_unit_macros.svh]
// assertion macros shared by the phase rotate accumulate rtl
`ifndef VISIBILITY_PHASE_ROTATE_ACCUMULATE_UNIT_MACROS_SVH
`define VISIBILITY_PHASE_ROTATE_ACCUMULATE_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define VPRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vpra assertion failed");
// next-cycle implication
`define VPRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vpra assertion failed");
`else
`define VPRA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VPRA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/vpra_pkg.sv]
// shared constants, types and helper functions of the phase rotate accumulate unit
package vpra_pkg;

  localparam int MAX_BASELINES = 1024;
  localparam int POL_LANES     = 4;
  localparam int CORDIC_ITERS  = 16;
  localparam int SLOT_W        = $clog2(MAX_BASELINES);
  localparam int MOD_W         = 11;
  localparam int ITER_W        = $clog2(CORDIC_ITERS);
  localparam int XW            = 35;
  localparam int ZW            = 34;
  localparam int PW            = XW + 32;
  localparam int ACC_W         = 64 * POL_LANES;
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_ROT,
    S_ACC,
    S_DONE
  } vpra_state_t;

  // request from the sequencer to the accumulator
  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] slot;
    logic              invalid;
    logic              zero_first;
  } acc_req_t;

  // arctangent in turns scaled by 2^32
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // signed 32-bit half plus signed 16-bit sample, saturated
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
    logic signed [32:0] s;
    s = 33'(signed'(a)) + 33'(signed'(b));
    if (s[32] != s[31]) begin
      return s[32] ? 32'h80000000 : 32'h7FFFFFFF;
    end
    return s[31:0];
  endfunction

endpackage

[rtl/core/vpra_phase.sv]
// phase angle from w difference times inverse wavelength, two partial products
module vpra_phase (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] w_rotated,
  input  logic [31:0] w_original,
  input  logic [31:0] inv_wavelength,
  output logic [31:0] angle
);
  import vpra_pkg::*;

  logic [39:0] diff;
  logic [39:0] p_lo_r, p_hi_r;
  logic [39:0] prod, neg;

  // only the low 40 bits of the turn count matter
  assign diff = 40'(signed'(w_rotated)) - 40'(signed'(w_original));

  // partial products registered at the transfer
  always_ff @(posedge clk) begin
    if (start) begin
      p_lo_r <= 40'(diff * 40'(inv_wavelength[15:0]));
      p_hi_r <= 40'(diff * 40'(inv_wavelength[31:16]));
    end
  end

  // combine, negate, take the fraction as a 32-bit angle
  assign prod  = p_lo_r + {p_hi_r[23:0], 16'h0000};
  assign neg   = 40'd0 - prod;
  assign angle = neg[39:8];

endmodule

[rtl/core/vpra_mod.sv]
// restoring remainder unit, one quotient bit per cycle
module vpra_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [15:0]                  dividend,
  input  logic [vpra_pkg::MOD_W-1:0]   divisor,
  output logic [vpra_pkg::SLOT_W-1:0]  slot,
  output logic                         done
);
  import vpra_pkg::*;

  logic [15:0]      num_r;
  logic [MOD_W-1:0] div_r, rem_r;
  logic [4:0]       cnt_r;
  logic             busy_r, done_r;
  logic [MOD_W:0]   trial;

  assign trial = {rem_r, num_r[15]};

  // shift in one dividend bit and subtract when it fits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
      num_r  <= dividend;
      div_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[14:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_r <= MOD_W'(trial - {1'b0, div_r});
      end else begin
        rem_r <= trial[MOD_W-1:0];
      end
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign slot = rem_r[SLOT_W-1:0];
  assign done = done_r;

endmodule

[rtl/core/vpra_cordic.sv]
// quadrant pre-rotation and iterative cordic over four polarization lanes
module vpra_cordic (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] angle,
  input  logic [31:0] vis [vpra_pkg::POL_LANES],
  output logic [31:0] rot [vpra_pkg::POL_LANES],
  output logic        done
);
  import vpra_pkg::*;

  logic signed [XW-1:0] x_r [POL_LANES];
  logic signed [XW-1:0] y_r [POL_LANES];
  logic signed [PW-1:0] px_r [POL_LANES];
  logic signed [PW-1:0] py_r [POL_LANES];
  logic signed [ZW-1:0] z_r;
  logic [ITER_W-1:0]    it_r;
  logic                 run_r, gain_r, rnd_r, done_r;
  logic [31:0]          rot_r [POL_LANES];
  logic [1:0]           quad;
  logic [31:0]          resid;
  logic signed [ZW-1:0] atan_v;

  assign quad   = 2'((angle + 32'h20000000) >> 30);
  assign resid  = angle - {quad, 30'd0};
  assign atan_v = ZW'(atan_turns(5'(it_r)));

  // round half up and clamp to q1.15
  function automatic logic [15:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + (PW'(1) <<< 45)) >>> 46;
    if (r[PW-1:15] != {(PW-15){r[PW-1]}}) begin
      return r[PW-1] ? 16'h8000 : 16'h7FFF;
    end
    return r[15:0];
  endfunction

  // sequence: load, iterate, gain multiply, round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      gain_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= rnd_r;
      rnd_r  <= gain_r;
      gain_r <= run_r && (it_r == ITER_W'(CORDIC_ITERS - 1));
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (it_r == ITER_W'(CORDIC_ITERS - 1))) begin
        run_r <= 1'b0;
      end
    end
  end

  // lane datapath
  always_ff @(posedge clk) begin
    if (start) begin
      it_r <= '0;
      z_r  <= ZW'(signed'(resid));
    end else if (run_r) begin
      it_r <= it_r + ITER_W'(1);
      z_r  <= z_r[ZW-1] ? z_r + atan_v : z_r - atan_v;
    end
    for (int p = 0; p < POL_LANES; p++) begin
      if (start) begin
        case (quad)
          2'd1: begin
            x_r[p] <= -XW'(signed'({vis[p][15:0], 16'h0000}));
            y_r[p] <=  XW'(signed'({vis[p][31:16], 16'h0000}));
          end
          2'd2: begin
            x_r[p] <= -XW'(signed'({vis[p][31:16], 16'h0000}));
            y_r[p] <= -XW'(signed'({vis[p][15:0], 16'h0000}));
          end
          2'd3: begin
            x_r[p] <=  XW'(signed'({vis[p][15:0], 16'h0000}));
            y_r[p] <= -XW'(signed'({vis[p][31:16], 16'h0000}));
          end
          default: begin
            x_r[p] <= XW'(signed'({vis[p][31:16], 16'h0000}));
            y_r[p] <= XW'(signed'({vis[p][15:0], 16'h0000}));
          end
        endcase
      end else if (run_r) begin
        if (!z_r[ZW-1]) begin
          x_r[p] <= x_r[p] - (y_r[p] >>> it_r);
          y_r[p] <= y_r[p] + (x_r[p] >>> it_r);
        end else begin
          x_r[p] <= x_r[p] + (y_r[p] >>> it_r);
          y_r[p] <= y_r[p] - (x_r[p] >>> it_r);
        end
      end
      if (gain_r) begin
        px_r[p] <= PW'(x_r[p]) * PW'(GAIN_Q30);
        py_r[p] <= PW'(y_r[p]) * PW'(GAIN_Q30);
      end
      if (rnd_r) begin
        rot_r[p] <= {round_sat(px_r[p]), round_sat(py_r[p])};
      end
    end
  end

  assign rot  = rot_r;
  assign done = done_r;

endmodule

[rtl/core/vpra_acc.sv]
// per-baseline accumulator memory with clearing sweep and saturating update
module vpra_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  vpra_pkg::acc_req_t  req,
  input  logic [31:0]         rot [vpra_pkg::POL_LANES],
  output logic [63:0]         sums [vpra_pkg::POL_LANES],
  output logic                done,
  output logic                clear_busy
);
  import vpra_pkg::*;

  logic [ACC_W-1:0]  mem [MAX_BASELINES];
  logic [ACC_W-1:0]  rdata_r, upd;
  logic [SLOT_W:0]   clr_cnt_r;
  logic              pend_r, done_r;
  logic [SLOT_W-1:0] slot_r;
  logic              inv_r, zero_r;
  logic [63:0]       sums_r [POL_LANES];
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [ACC_W-1:0]  wr_data;

  assign clear_busy = (clr_cnt_r != (SLOT_W+1)'(MAX_BASELINES));

  // clear sweep counter and update control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      pend_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      if (clear_busy) begin
        clr_cnt_r <= clr_cnt_r + (SLOT_W+1)'(1);
      end
      pend_r <= req.start;
      done_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      slot_r <= req.slot;
      inv_r  <= req.invalid;
      zero_r <= req.zero_first;
    end
  end

  // saturating add per polarization half
  always_comb begin
    for (int p = 0; p < POL_LANES; p++) begin
      upd[64*p +: 64] = zero_r ?
        {sat_add32(32'd0, rot[p][31:16]), sat_add32(32'd0, rot[p][15:0])} :
        {sat_add32(rdata_r[64*p+32 +: 32], rot[p][31:16]),
         sat_add32(rdata_r[64*p +: 32], rot[p][15:0])};
    end
  end

  // write port shared by the sweep and the update
  assign wr_en   = clear_busy || (pend_r && !inv_r);
  assign wr_addr = clear_busy ? clr_cnt_r[SLOT_W-1:0] : slot_r;
  assign wr_data = clear_busy ? '0 : upd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.start) begin
      rdata_r <= mem[req.slot];
    end
  end

  // result sums: stored entry for an invalid item, updated entry otherwise
  always_ff @(posedge clk) begin
    if (pend_r) begin
      for (int p = 0; p < POL_LANES; p++) begin
        sums_r[p] <= inv_r ? rdata_r[64*p +: 64] : upd[64*p +: 64];
      end
    end
  end

  assign sums = sums_r;
  assign done = done_r;

endmodule

[rtl/core/visibility_phase_rotate_accumulate_unit.sv]
// Phase rotation of four-polarization visibilities with per-baseline saturating
// accumulation. One item is in flight at a time. The phase product is registered at
// the input transfer, and the result then passes the cordic load, sixteen cordic
// iterations, a gain multiply and a rounding stage, a read-modify-write of the
// accumulator memory, the sequencer's done state and the output register. The next
// input transfer can follow in the cycle after the result is loaded. The baseline
// remainder runs alongside the cordic. A new item is taken while a finished result
// still waits in the output register. After reset the 1024-entry accumulator memory
// is cleared, one entry a cycle, and no item is taken until the sweep has ended;
// configuration writes are taken at any time.
module visibility_phase_rotate_accumulate_unit (
  input  logic         clk,
  input  logic         rst_n,
  // baseline_index, w_rotated, w_original, inv_wavelength, vis_pol0..vis_pol3
  input  logic [239:0] in_tdata,
  // sample_invalid, zero_before_add
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rot_pol0..rot_pol3, sum_pol0..sum_pol3
  output logic [383:0] out_tdata,
  // accumulated
  output logic         out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data
);
  import vpra_pkg::*;
`include "visibility_phase_rotate_accumulate_unit_macros.svh"

  vpra_state_t       state_r, state_nxt;
  logic [MOD_W-1:0]  num_baselines_r, mod_eff;
  logic [31:0]       vis_r [POL_LANES];
  logic [31:0]       vis_in [POL_LANES];
  logic              inv_r, zero_r;
  logic              in_xfer, load_out;
  logic [31:0]       angle;
  logic [31:0]       rot [POL_LANES];
  logic [63:0]       sums [POL_LANES];
  logic              rot_done, mod_done, acc_done, clear_busy;
  logic [SLOT_W-1:0] slot;
  acc_req_t          acc_req;
  logic [383:0]      out_data_r;
  logic              out_user_r, out_valid_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_baselines_r <= MOD_W'(1);
    end else if (cfg_wr_en) begin
      num_baselines_r <= cfg_wr_data;
    end
  end

  assign mod_eff = (num_baselines_r == '0) ? MOD_W'(1) :
                   (num_baselines_r > MOD_W'(MAX_BASELINES)) ? MOD_W'(MAX_BASELINES) :
                   num_baselines_r;

  assign in_xfer = in_tvalid && in_tready;

  // capture the samples and flags of the accepted item
  always_comb begin
    for (int p = 0; p < POL_LANES; p++) begin
      vis_in[p] = in_tdata[112 + 32*p +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vis_r  <= vis_in;
      inv_r  <= in_tuser[0];
      zero_r <= in_tuser[1];
    end
  end

  vpra_phase u_phase (
    .clk            (clk),
    .start          (in_xfer),
    .w_rotated      (in_tdata[47:16]),
    .w_original     (in_tdata[79:48]),
    .inv_wavelength (in_tdata[111:80]),
    .angle          (angle)
  );

  vpra_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .dividend (in_tdata[15:0]),
    .divisor  (mod_eff),
    .slot     (slot),
    .done     (mod_done)
  );

  vpra_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_PHASE),
    .angle (angle),
    .vis   (vis_r),
    .rot   (rot),
    .done  (rot_done)
  );

  assign acc_req = '{start:      (state_r == S_ROT) && rot_done,
                     slot:       slot,
                     invalid:    inv_r,
                     zero_first: zero_r};

  vpra_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (acc_req),
    .rot        (rot),
    .sums       (sums),
    .done       (acc_done),
    .clear_busy (clear_busy)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = !clear_busy;
        if (in_tvalid && !clear_busy) begin
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (rot_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (acc_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int p = 0; p < POL_LANES; p++) begin
        out_data_r[32*p +: 32]       <= rot[p];
        out_data_r[128 + 64*p +: 64] <= sums[p];
      end
      out_user_r <= !inv_r;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  `VPRA_ASSERT_IMP(a_ready_only_idle, clk, rst_n, in_tready, (state_r == S_IDLE) && !clear_busy)
  `VPRA_ASSERT_IMP(a_mod_before_acc, clk, rst_n, acc_req.start, mod_done)
  `VPRA_ASSERT_IMP(a_acc_done_in_acc, clk, rst_n, acc_done, state_r == S_ACC)
  `VPRA_ASSERT_NXT(a_load_sets_valid, clk, rst_n, load_out, out_tvalid)

endmodule

[verif/visibility_phase_rotate_accumulate_unit_checker.sv]
// checker that predicts and compares results of the phase rotate accumulate unit
`timescale 1ns / 1ps
module visibility_phase_rotate_accumulate_unit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [239:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [383:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  output int           fail_count,
  output int           pending_count
);
  import vpra_pkg::*;

  localparam longint GAIN = 64'sd652032874;
  localparam logic [31:0] ARCTAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic [31:0] rot [4];
    logic [63:0] sum [4];
    logic        accumulated;
  } rot_result_t;

  rot_result_t    expected_results [$];
  logic [63:0]    baseline_sums [4][MAX_BASELINES];
  logic [10:0]    baseline_modulus;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // quadrant pre-rotation, cordic and gain correction of one packed sample
  function automatic logic [31:0] rotate_pol(logic [31:0] pk, logic [31:0] ang);
    longint x, y, z, t, dx, dy;
    logic [31:0] shifted, resid;
    logic [1:0] quad;
    logic [15:0] xr, yr;
    x = longint'($signed(pk[31:16])) * 65536;
    y = longint'($signed(pk[15:0])) * 65536;
    shifted = ang + 32'h20000000;
    quad = shifted[31:30];
    resid = ang - {quad, 30'b0};
    z = longint'($signed(resid));
    case (quad)
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARCTAN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ARCTAN[i]);
      end
    end
    x = clamp_to((x * GAIN + (64'sd1 <<< 45)) >>> 46, -32768, 32767);
    y = clamp_to((y * GAIN + (64'sd1 <<< 45)) >>> 46, -32768, 32767);
    xr = x[15:0];
    yr = y[15:0];
    return {xr, yr};
  endfunction

  // saturating add of a rotated sample into one accumulator entry
  function automatic logic [63:0] add_to_sum(logic [63:0] e, logic [31:0] s);
    longint re, im;
    logic [31:0] rh, ih;
    re = clamp_to(longint'($signed(e[63:32])) + longint'($signed(s[31:16])),
                  -64'sd2147483648, 64'sd2147483647);
    im = clamp_to(longint'($signed(e[31:0])) + longint'($signed(s[15:0])),
                  -64'sd2147483648, 64'sd2147483647);
    rh = re[31:0];
    ih = im[31:0];
    return {rh, ih};
  endfunction

  function automatic rot_result_t predict_rotation(logic [239:0] d, logic [1:0] u);
    rot_result_t r;
    longint diff;
    logic [63:0] prod, neg;
    logic [31:0] ang;
    int modulus, slot;
    diff = longint'($signed(d[47:16])) - longint'($signed(d[79:48]));
    prod = 64'(diff) * {32'b0, d[111:80]};
    neg = 64'd0 - prod;
    ang = neg[39:8];
    modulus = (baseline_modulus == 0) ? 1 :
              (baseline_modulus > MAX_BASELINES) ? MAX_BASELINES : baseline_modulus;
    slot = int'(d[15:0]) % modulus;
    for (int p = 0; p < 4; p++) begin
      r.rot[p] = 32'd0;
      r.sum[p] = 64'd0;
      if (p < POL_LANES) begin
        r.rot[p] = rotate_pol(d[112 + 32*p +: 32], ang);
        if (u[0]) begin
          r.sum[p] = baseline_sums[p][slot];
        end else begin
          r.sum[p] = add_to_sum(u[1] ? 64'd0 : baseline_sums[p][slot], r.rot[p]);
          baseline_sums[p][slot] = r.sum[p];
        end
      end
    end
    r.accumulated = !u[0];
    return r;
  endfunction

  // watch config, input and result transfers
  always @(posedge clk) begin
    rot_result_t want;
    bit bad;
    if (!rst_n) begin
      baseline_modulus = 11'd1;
      for (int p = 0; p < 4; p++)
        for (int s = 0; s < MAX_BASELINES; s++) baseline_sums[p][s] = 64'd0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) baseline_modulus = cfg_wr_data;
      if (in_tvalid && in_tready)
        expected_results.insert(expected_results.size(), predict_rotation(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          bad = (want.accumulated != out_tuser);
          for (int p = 0; p < 4; p++)
            if (want.rot[p] != out_tdata[32*p +: 32] ||
                want.sum[p] != out_tdata[128 + 64*p +: 64]) bad = 1;
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t: accumulated exp %b got %b", $time,
                       want.accumulated, out_tuser);
              for (int p = 0; p < 4; p++)
                $display("  pol%0d rot exp %h got %h, sum exp %h got %h", p, want.rot[p],
                         out_tdata[32*p +: 32], want.sum[p], out_tdata[128 + 64*p +: 64]);
            end
          end
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

[verif/visibility_phase_rotate_accumulate_unit_tb.sv]
// stimulus and verdict for the phase rotate accumulate unit
`timescale 1ns / 1ps
module visibility_phase_rotate_accumulate_unit_tb;
  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 40;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [239:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] out_tdata;
  logic         out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [10:0]  cfg_wr_data = '0;
  int           fail_count, pending_count;
  int           idle_cycles = 0;
  bit           send_burst = 0, recv_burst = 0, long_hold = 0;

  visibility_phase_rotate_accumulate_unit dut (.*);
  visibility_phase_rotate_accumulate_unit_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random hold-off per transfer, one long hold on request
  always @(posedge clk) begin
    int wait_left;
    int hold_left;
    bit hold_used;
    if (long_hold && !hold_used) begin
      hold_left = 400;
      hold_used = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (wait_left > 0) begin
      wait_left--;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) wait_left = recv_burst ? 0 : $urandom_range(0, 14);
      out_tready <= (wait_left == 0);
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one item after a random gap; valid stays high when the next gap is zero
  task automatic send_vis(logic [239:0] d, logic [1:0] u);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= u;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_fields(logic [15:0] bl, logic [31:0] wr, logic [31:0] wo,
                             logic [31:0] iwl, logic [31:0] p0, logic [31:0] p1,
                             logic [31:0] p2, logic [31:0] p3, bit inval, bit zero_first);
    send_vis({p3, p2, p1, p0, iwl, wo, wr, bl}, {zero_first, inval});
  endtask

  // wait until every result is back, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [10:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_half();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_vis(int phase_items);
    logic [31:0] wr, wo, iwl;
    logic [31:0] pols [4];
    logic [15:0] bl;
    for (int n = 0; n < phase_items; n++) begin
      if (n % 60 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      bl = $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
      wr = $urandom;
      wo = $urandom_range(0, 2) == 0 ? $urandom : wr + 32'($urandom_range(0, 1 << 20))
                                                     - 32'd524288;
      iwl = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(1 << 24, 1 << 28));
      for (int p = 0; p < 4; p++) pols[p] = {random_half(), random_half()};
      send_fields(bl, wr, wo, iwl, pols[0], pols[1], pols[2], pols[3],
                  $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [10:0] moduli [8];
    moduli = '{11'd1024, 11'd2047, 11'd0, 11'd7, 11'd1, 11'd1000, 11'd37, 11'd1536};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero phase, half, quarter and eighth turns, extremes, flags
    send_fields(16'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF7FFF, 32'h80008000, 32'h0, 32'hFFFF0001,
                0, 0);
    send_fields(16'd0, 32'h00008000, 32'd0, 32'h01000000, 32'h7FFF0000, 32'h00007FFF,
                32'h80008000, 32'h12345678, 0, 0);
    send_fields(16'd3, 32'h00004000, 32'd0, 32'h01000000, 32'h7FFF0000, 32'h80000000,
                32'h7FFF7FFF, 32'h0001FFFF, 0, 0);
    send_fields(16'd3, 32'h00002000, 32'd0, 32'h01000000, 32'h7FFF7FFF, 32'h80008000,
                32'h40004000, 32'hC000C000, 0, 0);
    send_fields(16'd3, 32'hFFFFE000, 32'd0, 32'h01000000, 32'h7FFF7FFF, 32'h80008000,
                32'h40004000, 32'hC000C000, 0, 0);
    send_fields(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h7FFF8000,
                32'h80007FFF, 32'hFFFFFFFF, 32'hAAAA5555, 0, 0);
    send_fields(16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFF8000,
                32'h80007FFF, 32'hFFFFFFFF, 32'h5555AAAA, 0, 0);
    send_fields(16'd5, 32'h00010000, 32'd0, 32'h00800000, 32'h7FFF7FFF, 32'h7FFF7FFF,
                32'h7FFF7FFF, 32'h7FFF7FFF, 1, 0);
    send_fields(16'd5, 32'h00010000, 32'd0, 32'h00800000, 32'h7FFF7FFF, 32'h7FFF7FFF,
                32'h7FFF7FFF, 32'h7FFF7FFF, 1, 1);
    send_fields(16'd5, 32'h00000100, 32'h00000200, 32'h12345678, 32'h10002000, 32'h30004000,
                32'h50006000, 32'h70007000, 0, 1);
    send_fields(16'd9, 32'h00000100, 32'h00000200, 32'h12345678, 32'h10002000, 32'h30004000,
                32'h50006000, 32'h70007000, 0, 0);
    send_fields(16'd9, 32'd0, 32'd0, 32'd0, 32'h80008000, 32'h80008000, 32'h80008000,
                32'h80008000, 0, 0);
    drain();

    // random phases over several moduli, one with a long result hold
    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      if (k == 1) long_hold = 1;
      send_random_vis(250);
      long_hold = 0;
      drain();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/vpra_pkg.sv
rtl/core/vpra_phase.sv
rtl/core/vpra_mod.sv
rtl/core/vpra_cordic.sv
rtl/core/vpra_acc.sv
rtl/core/visibility_phase_rotate_accumulate_unit.sv
verif/visibility_phase_rotate_accumulate_unit_checker.sv
verif/visibility_phase_rotate_accumulate_unit_tb.sv
